// ===== src/spfs_pkg.sv =====
// Shared types and constants for the space packet frame splitter.
// No dependencies; every other file refers to it by scoped names.
package spfs_pkg;

    // Packet header layout and size rule
    localparam int          OIP_W        = 17;
    localparam logic [16:0] HDR_LEN_HIGH = 17'd4;
    localparam logic [16:0] HDR_LEN_LOW  = 17'd5;
    localparam logic [16:0] SIZE_EXTRA   = 17'd7;

    // Result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SPLIT = 2'd1,
        ST_NONE  = 2'd2,
        ST_LONG  = 2'd3
    } t_frame_status;

    // One result item
    typedef struct packed {
        logic          has_record;
        logic [15:0]   start_offset;
        logic [16:0]   packet_size;
        logic          is_split;
        logic          frame_end;
        t_frame_status frame_status;
    } t_result;

endpackage

// ===== src/spfs_front.sv =====
// Front end: per-byte packet parser with frame counters and the store_split register.
// Depends on spfs_pkg; pushes finished result beats into spfs_queue.
module spfs_front #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_beat,       // input beat accepted this cycle
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    output logic             o_push,
    output spfs_pkg::t_result o_result
);

    localparam int FOFS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [FOFS_W-1:0] FOFS_MAX  = FOFS_W'(MAX_FRAME_BYTES);
    localparam logic [FOFS_W-1:0] FOFS_SAT  = FOFS_W'(MAX_FRAME_BYTES + 1);

    logic [FOFS_W-1:0]         r_fofs, n_fofs;
    logic [15:0]               r_cstart, n_cstart;
    logic [spfs_pkg::OIP_W-1:0] r_oip, n_oip;
    logic [7:0]                r_lhb, n_lhb;
    logic [16:0]               r_csize, n_csize;
    logic                      r_stopped, n_stopped;
    logic                      r_seen, n_seen;
    logic                      r_store_split;

    logic [15:0]               pos_lo;
    logic [15:0]               len;
    logic [spfs_pkg::OIP_W-1:0] oip_inc;
    spfs_pkg::t_result         res;

    assign pos_lo = 16'(r_fofs);
    assign len    = {r_lhb, i_data_byte};

    // Parse one byte and build its result
    always_comb begin
        n_fofs    = r_fofs;
        n_cstart  = r_cstart;
        n_oip     = r_oip;
        n_lhb     = r_lhb;
        n_csize   = r_csize;
        n_stopped = r_stopped;
        n_seen    = r_seen;
        oip_inc   = r_oip + 17'd1;
        res       = '0;
        res.frame_status = spfs_pkg::ST_OK;

        if (r_fofs >= FOFS_MAX) begin
            n_fofs = FOFS_SAT;
        end else begin
            n_fofs = r_fofs + FOFS_W'(1);
            if (!r_stopped) begin
                if (r_oip == '0) begin
                    n_cstart = pos_lo;
                end
                if (r_oip == spfs_pkg::HDR_LEN_HIGH) begin
                    n_lhb = i_data_byte;
                end
                if (r_oip == spfs_pkg::HDR_LEN_LOW) begin
                    if (len == 16'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_csize = 17'(len) + spfs_pkg::SIZE_EXTRA;
                        n_seen  = 1'b1;
                    end
                end
                // packet complete
                if (!n_stopped && oip_inc > spfs_pkg::HDR_LEN_LOW && oip_inc == n_csize) begin
                    res.has_record   = 1'b1;
                    res.start_offset = n_cstart;
                    res.packet_size  = n_csize;
                    oip_inc          = '0;
                    n_csize          = '0;
                end
                n_oip = n_stopped ? '0 : oip_inc;
            end
        end

        // frame close: status, optional split record, clear per-frame state
        if (i_last) begin
            res.frame_end = 1'b1;
            priority if (n_fofs > FOFS_MAX) begin
                res.frame_status = spfs_pkg::ST_LONG;
            end else if (n_stopped) begin
                res.frame_status = n_seen ? spfs_pkg::ST_OK : spfs_pkg::ST_NONE;
            end else if (n_oip != '0) begin
                res.frame_status = spfs_pkg::ST_SPLIT;
                if (r_store_split) begin
                    res.has_record   = 1'b1;
                    res.start_offset = n_cstart;
                    res.packet_size  = n_oip;
                    res.is_split     = 1'b1;
                end
            end else begin
                res.frame_status = spfs_pkg::ST_OK;
            end
            n_fofs    = '0;
            n_cstart  = '0;
            n_oip     = '0;
            n_lhb     = '0;
            n_csize   = '0;
            n_stopped = 1'b0;
            n_seen    = 1'b0;
        end
    end

    assign o_push   = i_beat && (res.has_record || res.frame_end);
    assign o_result = res;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fofs    <= '0;
            r_cstart  <= '0;
            r_oip     <= '0;
            r_lhb     <= '0;
            r_csize   <= '0;
            r_stopped <= 1'b0;
            r_seen    <= 1'b0;
        end else if (i_beat) begin
            r_fofs    <= n_fofs;
            r_cstart  <= n_cstart;
            r_oip     <= n_oip;
            r_lhb     <= n_lhb;
            r_csize   <= n_csize;
            r_stopped <= n_stopped;
            r_seen    <= n_seen;
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_split <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_store_split <= i_cfg_wr_data;
        end
    end

    // A stop always parks the packet offset at zero
    a_stop_clears_oip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_oip == '0))
        else $error("offset in packet nonzero while stopped");

    // Frame end clears the frame counters
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_fofs == '0 && r_seen == 1'b0))
        else $error("frame state not cleared after last beat");

endmodule

// ===== src/spfs_queue.sv =====
// Small register queue of result items between parser and output stage.
// Depends on spfs_pkg for the result type and depth.
module spfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spfs_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output spfs_pkg::t_result o_data
);

    localparam int CNT_W = $clog2(spfs_pkg::QUEUE_DEPTH + 1);

    spfs_pkg::t_result              r_mem [spfs_pkg::QUEUE_DEPTH];
    logic [spfs_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [spfs_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]               r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == CNT_W'(spfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + spfs_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + spfs_pkg::QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(spfs_pkg::QUEUE_DEPTH))
        else $error("queue count over depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue push not counted");

endmodule

// ===== src/spfs_back.sv =====
// Back end: output register that drains the queue and packs result beats.
// Depends on spfs_pkg for the result type.
module spfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  spfs_pkg::t_result i_q_data,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [39:0]       o_tdata,
    output logic [3:0]        o_tuser,
    output logic              o_tlast
);

    logic              r_valid;
    spfs_pkg::t_result r_out;

    // Load when the register is empty or its beat is taken
    assign o_pop = i_q_valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_q_data;
        end
    end

    // Pack fields onto the bus
    assign o_tvalid = r_valid;
    assign o_tdata  = {7'd0, r_out.packet_size, r_out.start_offset};
    assign o_tuser  = {r_out.frame_status, r_out.is_split, r_out.has_record};
    assign o_tlast  = r_out.frame_end;

endmodule

// ===== src/space_packet_frame_splitter.sv =====
// Top level of the space packet frame splitter.
// Depends on spfs_pkg, spfs_front, spfs_queue and spfs_back.
//
// Usage:
//   Slave stream: one frame byte per beat in s_axis_tdata[7:0], s_axis_tlast on
//   the frame's last byte. Master stream: one result beat per finished packet
//   and one at each frame end (they share a beat when a packet closes the frame).
//   m_axis_tlast marks the frame end beat; m_axis_tuser carries the record flag,
//   split flag and frame status.
//   Throughput: one byte per cycle while the result queue is not full; the parser
//   updates its counters once per byte. A result reaches the master side through
//   the queue write and then the output register.
//   Stall: a four-entry result queue plus the output register absorb a stalled
//   receiver; s_axis_tready drops only once the queue is full.
//   Reset (i_rst_n low, synchronous) clears all frame state, the queue and
//   store_split. store_split is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   must write it only while the block is idle, and the block does not enforce this.
module space_packet_frame_splitter #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,   // store_split
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // last_in_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [15:0] start_offset, [32:16] packet_size, zero pad
    output logic [3:0]  m_axis_tuser,    // [0] has_record, [1] is_split, [3:2] frame_status
    output logic        m_axis_tlast     // frame_end
);

    logic              beat;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    spfs_pkg::t_result push_data;
    spfs_pkg::t_result q_data;

    assign s_axis_tready = !q_full;
    assign beat          = s_axis_tvalid && s_axis_tready;

    spfs_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_beat        (beat),
        .i_data_byte   (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_result      (push_data)
    );

    spfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    spfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule
